/* rtl/onav_pkg.sv */
// ----------------------------------------------------------------------------
// onav_pkg
// Shared types, widths and constants of the optical navigation direction
// decoder.
// ----------------------------------------------------------------------------
package onav_pkg;

  // field widths
  localparam int CMD_W   = 2;
  localparam int DELTA_W = 8;
  localparam int TIME_W  = 32;
  localparam int TIDX_W  = 5;
  localparam int STEP_W  = 8;
  localparam int DIR_W   = 3;
  localparam int SUM_W   = 16;
  localparam int RATIO_W = 7;
  localparam int THR_W   = 7;
  localparam int REP_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam int STEP_ENTRIES_DEF = 32;
  localparam int CHANGE_WINDOW_MS = 80;
  localparam int RATIO_SCALE      = 10;

  // configuration reset values
  localparam logic [RATIO_W-1:0] RATIO_RST  = RATIO_W'(10);
  localparam logic [THR_W-1:0]   THR_RST    = THR_W'(8);
  localparam logic [REP_W-1:0]   REPEAT_RST = REP_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_RATIO = 2'd0,
    CFG_MOVE_THR   = 2'd1,
    CFG_REPEAT_MS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_MOTION = 2'd0,
    CMD_WR_X   = 2'd1,
    CMD_WR_Y   = 2'd2
  } cmd_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TBL_WR,
    ST_ACCUM,
    ST_MAG,
    ST_PROD,
    ST_DECIDE,
    ST_CHECK,
    ST_DIV,
    ST_LOOKUP,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [THR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/optical_nav_direction_decoder_top.sv */
// ----------------------------------------------------------------------------
// optical_nav_direction_decoder_top
// Sums optical motion samples and turns them into direction events with a
// step count looked up from per-axis tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: a motion
//   sample (command 0) or a step table write (commands 1, 2). Output channel
//   (out_valid_o / out_ready_i) carries at most one result per item: a
//   direction and its step count. cfg_we_i writes a register.
//   A table write returns to idle after its write step; a motion sample
//   without an event passes accumulate, magnitude, product and decide;
//   an event goes on through check, the serial divider that forms the
//   table index (sum over threshold), lookup and result. One item is
//   processed at a time; in_ready_o is high only while the sequencer is idle.
//   The result sits in an output register, so the next item can be accepted
//   while a result still waits; if an earlier result has not been taken,
//   the sequencer holds in its result step until the receiver takes it.
//   Reset clears sums, times, the last direction and the table valid bits
//   (tables read as zero until written), and loads the register defaults.
// ----------------------------------------------------------------------------
module optical_nav_direction_decoder_top #(
  parameter int STEP_ENTRIES = onav_pkg::STEP_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [onav_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [onav_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [onav_pkg::CMD_W-1:0]          command_i,
  input  logic signed [onav_pkg::DELTA_W-1:0] delta_x_i,
  input  logic signed [onav_pkg::DELTA_W-1:0] delta_y_i,
  input  logic [onav_pkg::TIME_W-1:0]         time_ms_i,
  input  logic                                burst_start_i,
  input  logic [onav_pkg::TIDX_W-1:0]         table_index_i,
  input  logic [onav_pkg::STEP_W-1:0]         table_value_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [onav_pkg::DIR_W-1:0]          direction_o,
  output logic [onav_pkg::STEP_W-1:0]         step_count_o
);

  localparam int SW        = onav_pkg::SUM_W;
  localparam int TW        = onav_pkg::TIME_W;
  localparam int IDX_W     = $clog2(STEP_ENTRIES);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 * (2 ** IDX_W);
  localparam int PY_W      = SW + 4;
  localparam int PX_W      = SW + onav_pkg::RATIO_W;

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    logic signed [SW:0] w;
    w = (SW+1)'(0) - (SW+1)'(v);
    mag = v[SW-1] ? w[SW-1:0] : v;
  endfunction

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [onav_pkg::DELTA_W-1:0] d);
    logic signed [SW:0] s;
    s = (SW+1)'(a) + (SW+1)'(d);
    if (s[SW] != s[SW-1]) begin
      sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sat_add = s[SW-1:0];
    end
  endfunction

  // configuration
  logic [onav_pkg::RATIO_W-1:0] ratio_q;
  logic [onav_pkg::THR_W-1:0]   thr_q;
  logic [onav_pkg::REP_W-1:0]   rep_q;

  // sequencer
  onav_pkg::state_e state_q, state_d;

  // latched item
  logic [onav_pkg::CMD_W-1:0]          cmd_q;
  logic signed [onav_pkg::DELTA_W-1:0] dx_q, dy_q;
  logic [TW-1:0]                       now_q;
  logic                                burst_q;
  logic [onav_pkg::TIDX_W-1:0]         tix_q;
  logic [onav_pkg::STEP_W-1:0]         tval_q;

  // architectural state
  logic signed [SW-1:0] x_acc_q, y_acc_q;
  logic [TW-1:0]        burst_time_q;
  logic [TW-1:0]        last_evt_q;
  onav_pkg::dir_e       last_dir_q;

  // working registers
  logic [SW-1:0]   ax_q, ay_q;
  logic [PY_W-1:0] prod_y_q;
  logic [PX_W-1:0] prod_x_q;
  onav_pkg::dir_e  dir_q;
  logic [IDX_W-1:0] idx_q;
  logic            vld_rd_q;
  logic [RAM_DEPTH-1:0] tbl_vld_q;

  // output register
  logic                        out_valid_q;
  logic [onav_pkg::DIR_W-1:0]  out_dir_q;
  logic [onav_pkg::STEP_W-1:0] out_step_q;

  // combinational
  logic               in_acc;
  logic               out_load;
  onav_pkg::dir_e     dir_pick;
  logic [TW-1:0]      elapsed;
  logic               drop;
  logic               wr_ok;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [onav_pkg::STEP_W-1:0] ram_rdata;
  logic [IDX_W-1:0]   idx_next;
  logic               vert;
  onav_pkg::div_req_t div_req;
  onav_pkg::div_rsp_t div_rsp;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_load = (state_q == onav_pkg::ST_RESULT) && (!out_valid_q || out_ready_i);
  assign vert     = (dir_q == onav_pkg::DIR_UP) || (dir_q == onav_pkg::DIR_DOWN);

  always_comb begin
    // ratio test; products registered in the previous step
    if ((PX_W'(prod_y_q) > prod_x_q) && ay_q > SW'(thr_q)) begin
      dir_pick = (y_acc_q > 0) ? onav_pkg::DIR_UP : onav_pkg::DIR_DOWN;
    end else if (ax_q > SW'(thr_q)) begin
      dir_pick = (x_acc_q > 0) ? onav_pkg::DIR_RIGHT : onav_pkg::DIR_LEFT;
    end else begin
      dir_pick = onav_pkg::DIR_NONE;
    end
  end

  always_comb begin
    elapsed = now_q - last_evt_q;
    drop    = (elapsed < TW'(rep_q))
              || ((elapsed < TW'(onav_pkg::CHANGE_WINDOW_MS)) && (dir_q != last_dir_q));
  end

  always_comb begin
    if (thr_q == '0 || div_rsp.quot > SW'(STEP_ENTRIES - 1)) begin
      idx_next = IDX_W'(STEP_ENTRIES - 1);
    end else begin
      idx_next = div_rsp.quot[IDX_W-1:0];
    end
  end

  // table write goes to the X half or the Y half of one RAM
  assign wr_ok     = 9'(tix_q) < 9'(STEP_ENTRIES);
  assign ram_we    = (state_q == onav_pkg::ST_TBL_WR) && wr_ok;
  assign ram_waddr = {(onav_pkg::cmd_e'(cmd_q) == onav_pkg::CMD_WR_Y), IDX_W'(9'(tix_q))};
  assign ram_re    = (state_q == onav_pkg::ST_LOOKUP);
  assign ram_raddr = {vert, idx_q};

  assign div_req.start    = (state_q == onav_pkg::ST_CHECK) && !drop;
  assign div_req.dividend = vert ? ay_q : ax_q;
  assign div_req.divisor  = thr_q;

  onav_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  onav_ram #(
    .WIDTH (onav_pkg::STEP_W),
    .DEPTH (RAM_DEPTH)
  ) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tval_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      onav_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (onav_pkg::cmd_e'(command_i) == onav_pkg::CMD_MOTION) begin
            state_d = onav_pkg::ST_ACCUM;
          end else if (onav_pkg::cmd_e'(command_i) == onav_pkg::CMD_WR_X
                       || onav_pkg::cmd_e'(command_i) == onav_pkg::CMD_WR_Y) begin
            state_d = onav_pkg::ST_TBL_WR;
          end
        end
      end
      onav_pkg::ST_TBL_WR: state_d = onav_pkg::ST_IDLE;
      onav_pkg::ST_ACCUM:  state_d = onav_pkg::ST_MAG;
      onav_pkg::ST_MAG:    state_d = onav_pkg::ST_PROD;
      onav_pkg::ST_PROD:   state_d = onav_pkg::ST_DECIDE;
      onav_pkg::ST_DECIDE: begin
        state_d = (dir_pick == onav_pkg::DIR_NONE) ? onav_pkg::ST_IDLE : onav_pkg::ST_CHECK;
      end
      onav_pkg::ST_CHECK:  state_d = drop ? onav_pkg::ST_IDLE : onav_pkg::ST_DIV;
      onav_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = onav_pkg::ST_LOOKUP;
        end
      end
      onav_pkg::ST_LOOKUP: state_d = onav_pkg::ST_RESULT;
      onav_pkg::ST_RESULT: begin
        if (out_load) begin
          state_d = onav_pkg::ST_IDLE;
        end
      end
      default: state_d = onav_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= onav_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= onav_pkg::RATIO_RST;
      thr_q   <= onav_pkg::THR_RST;
      rep_q   <= onav_pkg::REPEAT_RST;
    end else if (cfg_we_i) begin
      unique case (onav_pkg::cfg_reg_e'(cfg_idx_i))
        onav_pkg::CFG_AXIS_RATIO: ratio_q <= cfg_wdata_i[onav_pkg::RATIO_W-1:0];
        onav_pkg::CFG_MOVE_THR:   thr_q   <= cfg_wdata_i[onav_pkg::THR_W-1:0];
        onav_pkg::CFG_REPEAT_MS:  rep_q   <= cfg_wdata_i[onav_pkg::REP_W-1:0];
        default: ;
      endcase
    end
  end

  // item latch and working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= command_i;
      dx_q    <= delta_x_i;
      dy_q    <= delta_y_i;
      now_q   <= time_ms_i;
      burst_q <= burst_start_i;
      tix_q   <= table_index_i;
      tval_q  <= table_value_i;
    end
    if (state_q == onav_pkg::ST_MAG) begin
      ax_q <= mag(x_acc_q);
      ay_q <= mag(y_acc_q);
    end
    if (state_q == onav_pkg::ST_PROD) begin
      prod_y_q <= PY_W'(ay_q) * PY_W'(onav_pkg::RATIO_SCALE);
      prod_x_q <= PX_W'(ax_q) * PX_W'(ratio_q);
    end
    if (state_q == onav_pkg::ST_DECIDE) begin
      dir_q <= dir_pick;
    end
    if (state_q == onav_pkg::ST_DIV && div_rsp.done) begin
      idx_q <= idx_next;
    end
    if (state_q == onav_pkg::ST_LOOKUP) begin
      vld_rd_q <= tbl_vld_q[ram_raddr];
    end
    if (out_load) begin
      out_dir_q  <= dir_q;
      out_step_q <= vld_rd_q ? ram_rdata : '0;
    end
  end

  // sums, event bookkeeping, table valid bits and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_acc_q      <= '0;
      y_acc_q      <= '0;
      burst_time_q <= '0;
      last_evt_q   <= '0;
      last_dir_q   <= onav_pkg::DIR_NONE;
      tbl_vld_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == onav_pkg::ST_ACCUM) begin
        x_acc_q <= sat_add(burst_q ? '0 : x_acc_q, dx_q);
        y_acc_q <= sat_add(burst_q ? '0 : y_acc_q, dy_q);
        if (burst_q) begin
          burst_time_q <= now_q;
        end
      end
      // first event: back-date the last event so the burst entry counts
      if (state_q == onav_pkg::ST_DECIDE && dir_pick != onav_pkg::DIR_NONE
          && last_evt_q == '0) begin
        last_evt_q <= burst_time_q - TW'(rep_q);
        last_dir_q <= dir_pick;
      end
      if (state_q == onav_pkg::ST_CHECK && !drop) begin
        last_evt_q <= now_q;
        last_dir_q <= dir_q;
        x_acc_q    <= '0;
        y_acc_q    <= '0;
      end
      if (ram_we) begin
        tbl_vld_q[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o   = (state_q == onav_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign direction_o  = out_dir_q;
  assign step_count_o = out_step_q;

endmodule

/* rtl/onav_ram.sv */
// ----------------------------------------------------------------------------
// onav_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module onav_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/onav_div.sv */
// ----------------------------------------------------------------------------
// onav_div
// Restoring divider, one quotient bit per cycle: sum magnitude over
// threshold.
// ----------------------------------------------------------------------------
module onav_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  onav_pkg::div_req_t req_i,
  output onav_pkg::div_rsp_t rsp_o
);

  localparam int SW = onav_pkg::SUM_W;
  localparam int TW = onav_pkg::THR_W;
  localparam int CW = onav_pkg::DIV_CNT_W;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [TW-1:0] rem_q;
  logic [SW-1:0] dq_q;
  logic [TW-1:0] dsr_q;

  logic [TW:0] shifted;
  logic [TW:0] diff;
  logic        ge;

  always_comb begin
    shifted = {rem_q, dq_q[SW-1]};
    ge      = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(SW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder stays below the divisor, so it fits the divisor width
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dq_q  <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TW-1:0] : shifted[TW-1:0];
      dq_q  <= {dq_q[SW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;

endmodule
